### hw/rtl/sspg_pkg.sv
// Shared constants, register codes and types of the stride shadow prefetch generator.
// Used by the top level and by the history ring memory.
package sspg_pkg;

	localparam int NUM_CORES     = 4;
	localparam int HISTORY_DEPTH = 16;
	localparam int CORE_W        = 2;
	localparam int ADDR_W        = 64;
	localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
	localparam int RING_DEPTH    = NUM_CORES * HISTORY_DEPTH;
	localparam int RING_AW       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CONF_W        = 2;
	localparam int DEPTH_W       = 5;
	localparam int S_TDATA_W     = 72;
	localparam int PADDR_W       = 4;

	localparam logic [CONF_W-1:0] CONF_MAX    = 2'd3;
	localparam logic [CONF_W-1:0] CONF_THRESH = 2'd2;
	localparam logic [ADDR_W-1:0] FIXED_OFFSET = 64'd64;

	// warm_policy codes
	localparam logic [1:0] WP_NONE   = 2'd0;
	localparam logic [1:0] WP_NEXT   = 2'd1;
	localparam logic [1:0] WP_REPLAY = 2'd2;

	// offset_policy codes
	localparam logic [1:0] OP_FIXED  = 2'd0;
	localparam logic [1:0] OP_STRIDE = 2'd1;
	localparam logic [1:0] OP_AUTO   = 2'd2;

	// register indexes (byte address 4*i)
	localparam logic [1:0] REG_WARM_POLICY   = 2'd0;
	localparam logic [1:0] REG_REPLAY_DEPTH  = 2'd1;
	localparam logic [1:0] REG_OFFSET_POLICY = 2'd2;

	// input mode
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_MISP = 1'b1;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [RING_AW-1:0] addr;
	} ring_req_t;

endpackage

### hw/rtl/stride_shadow_prefetch_generator.sv
// Top level of the stride shadow prefetch generator: sequencer, per-core stride state,
// shared 64-bit adder, output register and APB register file. Depends on sspg_pkg, sspg_ring.
//
// Usage:
//   Input stream s_*: s_tuser is the mode (0 committed load, 1 mispredict marker),
//   s_tdata carries the core index and the load line address. One item is taken at a
//   time; s_tready is high only while the sequencer is idle.
//   Output stream m_*: each transfer is one warm line address; m_tlast marks the final
//   address caused by an input item.
//   Sequencing: a load passes the idle and offset/emit steps, and a train step when the
//   stride detector trains (the shared adder does the emit sum and then the stride
//   difference). A mispredict passes idle and a miss step, then a read and an emit step
//   per replayed line: each line needs one registered read of the single-port history
//   memory and one adder pass. A load result shows on m_* in the cycle after its offset step.
//   Stall: when the receiver holds m_tready low, the result waits in the output
//   register and the sequencer holds in its emit step until the register frees.
//   Reset: all per-core counters and stride state clear, replay_depth reads 16, the
//   other registers 0. The history memory is not cleared; only written entries are read.
//   Registers must be written through APB only while idle; the block does not enforce it.
module stride_shadow_prefetch_generator
	import sspg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] core, [65:2] line_addr, [71:66] zero
	input  logic                 s_tuser,  // [0] mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [ADDR_W-1:0]    m_tdata,  // [63:0] warm_addr
	output logic                 m_tlast,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_TRAIN = 6'b000100,
		ST_MISS  = 6'b001000,
		ST_RD    = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	logic [1:0]         warm_policy_q;
	logic [DEPTH_W-1:0] replay_depth_q;
	logic [1:0]         offset_policy_q;

	logic [CORE_W-1:0] core_q;
	logic [ADDR_W-1:0] line_q;

	logic [IDX_W-1:0]  head_q   [NUM_CORES];
	logic [FILL_W-1:0] fill_q   [NUM_CORES];
	logic [ADDR_W-1:0] prior_q  [NUM_CORES];
	logic [ADDR_W-1:0] stride_q [NUM_CORES];
	logic [CONF_W-1:0] conf_q   [NUM_CORES];
	logic              primed_q [NUM_CORES];

	logic [FILL_W-1:0] take_q;
	logic [FILL_W-1:0] k_q;
	logic [ADDR_W-1:0] off_q;

	logic              m_tvalid_q;
	logic [ADDR_W-1:0] m_tdata_q;
	logic              m_tlast_q;

	logic [IDX_W-1:0]  cur_head;
	logic [FILL_W-1:0] cur_fill;
	logic [ADDR_W-1:0] cur_prior;
	logic [ADDR_W-1:0] cur_stride;
	logic [CONF_W-1:0] cur_conf;
	logic              cur_primed;

	logic              confident;
	logic [ADDR_W-1:0] off_sel;
	logic              off_ok;
	logic [FILL_W-1:0] depth_cl;
	logic [FILL_W-1:0] take;
	logic [IDX_W:0]    ridx_sum;
	logic [IDX_W-1:0]  ridx;
	logic [IDX_W-1:0]  ring_idx;

	logic [ADDR_W-1:0] alu_a;
	logic [ADDR_W-1:0] alu_b;
	logic              alu_cin;
	logic [ADDR_W-1:0] alu_sum;

	logic              s_core_ok;
	logic              out_free;
	logic              emit_load;
	logic              train_en;
	logic              load_go;
	logic              load_out;
	logic              emit_last;
	logic              cfg_we;

	ring_req_t         ring_req;
	logic [ADDR_W-1:0] ring_rdata;

	// current core state
	assign cur_head   = head_q[core_q];
	assign cur_fill   = fill_q[core_q];
	assign cur_prior  = prior_q[core_q];
	assign cur_stride = stride_q[core_q];
	assign cur_conf   = conf_q[core_q];
	assign cur_primed = primed_q[core_q];

	assign confident = (cur_conf >= CONF_THRESH) && (cur_stride != '0);

	always_comb begin
		off_sel = FIXED_OFFSET;
		off_ok  = 1'b1;
		case (offset_policy_q)
			OP_STRIDE: begin
				off_sel = cur_stride;
				off_ok  = confident;
			end
			OP_AUTO: begin
				if (confident) begin
					off_sel = cur_stride;
				end
			end
			default: begin
				off_sel = FIXED_OFFSET;
			end
		endcase
	end

	assign depth_cl = (replay_depth_q > DEPTH_W'(HISTORY_DEPTH)) ?
		FILL_W'(HISTORY_DEPTH) : FILL_W'(replay_depth_q);
	assign take = (depth_cl < cur_fill) ? depth_cl : cur_fill;

	// newest first: head - 1 - k, modulo ring size
	assign ridx_sum = {1'b0, cur_head} + (IDX_W+1)'(HISTORY_DEPTH - 1) - (IDX_W+1)'(k_q);
	assign ridx = (ridx_sum >= (IDX_W+1)'(HISTORY_DEPTH)) ?
		IDX_W'(ridx_sum - (IDX_W+1)'(HISTORY_DEPTH)) : IDX_W'(ridx_sum);

	// shared adder
	always_comb begin
		alu_a   = line_q;
		alu_b   = off_sel;
		alu_cin = 1'b0;
		case (state_q)
			ST_TRAIN: begin
				alu_b   = ~cur_prior;
				alu_cin = 1'b1;
			end
			ST_EMIT: begin
				alu_a = ring_rdata;
				alu_b = off_q;
			end
			default: begin
				alu_a = line_q;
			end
		endcase
	end

	assign alu_sum = alu_a + alu_b + {{(ADDR_W-1){1'b0}}, alu_cin};

	assign s_core_ok = 32'(s_tdata[CORE_W-1:0]) < 32'(NUM_CORES);
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_load = (warm_policy_q == WP_NEXT) && off_ok;
	assign train_en  = (offset_policy_q == OP_STRIDE) || (offset_policy_q == OP_AUTO);
	assign load_go   = !emit_load || out_free;
	assign emit_last = (FILL_W'(k_q + 1'b1) == take_q);
	assign load_out  = ((state_q == ST_LOAD) && emit_load && out_free) ||
		((state_q == ST_EMIT) && out_free);

	assign ring_idx      = (state_q == ST_RD) ? ridx : cur_head;
	assign ring_req.we   = (state_q == ST_LOAD) && load_go && (warm_policy_q == WP_REPLAY);
	assign ring_req.re   = (state_q == ST_RD);
	assign ring_req.addr = RING_AW'(core_q) * RING_AW'(HISTORY_DEPTH) + RING_AW'(ring_idx);

	sspg_ring u_ring (
		.clk   (clk),
		.req   (ring_req),
		.wdata (line_q),
		.rdata (ring_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (!s_core_ok) begin
						state_nxt = ST_IDLE;
					end else if (s_tuser == MODE_MISP) begin
						state_nxt = ST_MISS;
					end else begin
						state_nxt = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				if (load_go) begin
					state_nxt = train_en ? ST_TRAIN : ST_IDLE;
				end
			end
			ST_TRAIN: begin
				state_nxt = ST_IDLE;
			end
			ST_MISS: begin
				if ((warm_policy_q == WP_REPLAY) && off_ok && (take != '0)) begin
					state_nxt = ST_RD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RD: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_nxt = emit_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// item capture and replay sequencing
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			core_q <= s_tdata[CORE_W-1:0];
			line_q <= s_tdata[CORE_W +: ADDR_W];
		end
		if (state_q == ST_MISS) begin
			take_q <= take;
			off_q  <= off_sel;
			k_q    <= '0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			k_q <= FILL_W'(k_q + 1'b1);
		end
	end

	// per-core ring pointers and stride detector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				head_q[i]   <= '0;
				fill_q[i]   <= '0;
				prior_q[i]  <= '0;
				stride_q[i] <= '0;
				conf_q[i]   <= '0;
				primed_q[i] <= 1'b0;
			end
		end else begin
			if (ring_req.we) begin
				head_q[core_q] <= (cur_head == IDX_W'(HISTORY_DEPTH - 1)) ?
					'0 : IDX_W'(cur_head + 1'b1);
				if (cur_fill < FILL_W'(HISTORY_DEPTH)) begin
					fill_q[core_q] <= FILL_W'(cur_fill + 1'b1);
				end
			end
			if (state_q == ST_TRAIN) begin
				prior_q[core_q] <= line_q;
				if (!cur_primed) begin
					primed_q[core_q] <= 1'b1;
				end else if (alu_sum != '0) begin
					if (alu_sum == cur_stride) begin
						if (cur_conf < CONF_MAX) begin
							conf_q[core_q] <= CONF_W'(cur_conf + 1'b1);
						end
					end else if (cur_conf != '0) begin
						conf_q[core_q] <= CONF_W'(cur_conf - 1'b1);
					end else begin
						stride_q[core_q] <= alu_sum;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= alu_sum;
			m_tlast_q <= (state_q == ST_LOAD) ? 1'b1 : emit_last;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// register file
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_policy_q   <= WP_NONE;
			replay_depth_q  <= DEPTH_W'(16);
			offset_policy_q <= OP_FIXED;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_WARM_POLICY:   warm_policy_q   <= pwdata[1:0];
				REG_REPLAY_DEPTH:  replay_depth_q  <= pwdata[DEPTH_W-1:0];
				REG_OFFSET_POLICY: offset_policy_q <= pwdata[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_WARM_POLICY:   prdata = {30'b0, warm_policy_q};
			REG_REPLAY_DEPTH:  prdata = {{(32-DEPTH_W){1'b0}}, replay_depth_q};
			REG_OFFSET_POLICY: prdata = {30'b0, offset_policy_q};
			default:           prdata = '0;
		endcase
	end

endmodule

### hw/rtl/sspg_ring.sv
// History ring storage for all cores: one port, write or registered read per cycle.
// Depends on sspg_pkg.
module sspg_ring
	import sspg_pkg::*;
(
	input  logic              clk,
	input  ring_req_t         req,
	input  logic [ADDR_W-1:0] wdata,
	output logic [ADDR_W-1:0] rdata
);

	logic [ADDR_W-1:0] mem [RING_DEPTH];
	logic [ADDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/sspg_checker.sv
// Port-level checks of the stride shadow prefetch generator, bound to the top level.
// Depends on sspg_pkg and stride_shadow_prefetch_generator.
module sspg_checker
	import sspg_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [ADDR_W-1:0] m_tdata,
	input logic              m_tlast,
	input logic              pready
);

	// one item in flight: no transfer right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	// a replay run blocks input until its last result is in the output register
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid || !s_tready)
		else $error("input accepted inside a replay run");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind stride_shadow_prefetch_generator sspg_checker u_sspg_checker (.*);
